// ----- rtl/clpfm_pkg.sv -----
// ----------------------------------------------------------------------------
// clpfm_pkg
// Shared widths, constants and types of the CPU load percent fault monitor.
// ----------------------------------------------------------------------------
package clpfm_pkg;

  localparam int NumCpus    = 8;
  localparam int CountWidth = 64;
  localparam int IdxW       = 4;
  localparam int PctW       = 15;
  localparam int Depth      = NumCpus + 1;
  localparam int SlotW      = $clog2(Depth);

  localparam logic [PctW-1:0] FullPct = PctW'(25600);

  localparam logic [1:0] PhCleared   = 2'd0;
  localparam logic [1:0] PhAsserting = 2'd1;
  localparam logic [1:0] PhAsserted  = 2'd2;
  localparam logic [1:0] PhClearing  = 2'd3;

  localparam logic [1:0] EvNone    = 2'd0;
  localparam logic [1:0] EvAsserted = 2'd1;
  localparam logic [1:0] EvCleared = 2'd2;

  localparam logic [1:0] RegLoadLimit     = 2'd0;
  localparam logic [1:0] RegAssertTimeout = 2'd1;
  localparam logic [1:0] RegClearTimeout  = 2'd2;

  typedef logic [CountWidth-1:0] cnt_t;

  typedef struct packed {
    logic start;
    cnt_t num;
    cnt_t den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [PctW-1:0] pct;
  } div_rsp_t;

endpackage

// ----- rtl/clpfm_divider.sv -----
// ----------------------------------------------------------------------------
// clpfm_divider
// Shared restoring divider: floor(num * 25600 / den), saturated at 25600.
// One quotient bit per cycle, after the DvMulLo and DvMulHi steps form the scaled dividend.
// ----------------------------------------------------------------------------
module clpfm_divider
  import clpfm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  typedef enum logic [1:0] {DvIdle, DvMulLo, DvMulHi, DvRun} dv_state_e;

  localparam int CntW = $clog2(CountWidth + 1);

  dv_state_e        state_q;
  logic [CntW-1:0]  cnt_q;
  cnt_t             den_q, num_q, rem_q, lo_q, q_q;
  logic [2*CountWidth-1:0] prod_q;
  logic             sat_q;
  logic             done_q;
  logic [PctW-1:0]  pct_q;

  // 32x15 partial products
  localparam int HalfW = CountWidth / 2;
  logic [HalfW+PctW-1:0] part;
  logic                  carry;
  cnt_t                  shifted;
  logic [CountWidth:0]   diff;

  always_comb begin
    part    = (state_q == DvMulLo) ? num_q[HalfW-1:0] * FullPct
                                   : num_q[CountWidth-1:HalfW] * FullPct;
    carry   = rem_q[CountWidth-1];
    shifted = {rem_q[CountWidth-2:0], lo_q[CountWidth-1]};
    diff    = {1'b0, shifted} - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DvIdle;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == DvRun) && (cnt_q == CntW'(1));
      unique case (state_q)
        DvIdle: begin
          if (req_i.start) begin
            num_q   <= req_i.num;
            den_q   <= req_i.den;
            sat_q   <= (req_i.num >= req_i.den);
            prod_q  <= '0;
            state_q <= DvMulLo;
          end
        end
        DvMulLo: begin
          prod_q  <= (2*CountWidth)'(part);
          state_q <= DvMulHi;
        end
        DvMulHi: begin
          rem_q   <= prod_q[2*CountWidth-1:CountWidth]
                     + cnt_t'(((2*CountWidth)'(part) << HalfW) >> CountWidth)
                     + cnt_t'({1'b0, prod_q[CountWidth-1:0]}
                              + {1'b0, cnt_t'((2*CountWidth)'(part) << HalfW)}
                              >> CountWidth);
          lo_q    <= prod_q[CountWidth-1:0] + cnt_t'((2*CountWidth)'(part) << HalfW);
          q_q     <= '0;
          cnt_q   <= CntW'(CountWidth);
          state_q <= DvRun;
        end
        DvRun: begin
          lo_q <= {lo_q[CountWidth-2:0], 1'b0};
          if (carry || !diff[CountWidth]) begin
            rem_q <= diff[CountWidth-1:0];
            q_q   <= {q_q[CountWidth-2:0], 1'b1};
          end else begin
            rem_q <= shifted;
            q_q   <= {q_q[CountWidth-2:0], 1'b0};
          end
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CntW'(1)) begin
            state_q <= DvIdle;
          end
        end
        default: state_q <= DvIdle;
      endcase
    end
  end

  // quotient is complete in the cycle done is raised
  cnt_t q_fin;
  assign q_fin = q_q;

  always_comb begin
    if (sat_q || q_fin > cnt_t'(FullPct)) pct_q = FullPct;
    else                                  pct_q = q_fin[PctW-1:0];
  end

  assign rsp_o.done = done_q;
  assign rsp_o.pct  = pct_q;

endmodule

// ----- rtl/cpu_load_percent_fault_monitor.sv -----
// ----------------------------------------------------------------------------
// cpu_load_percent_fault_monitor
// Per-CPU load percentages from cumulative counters and a load fault machine.
// ----------------------------------------------------------------------------
// Snapshot word: result valid after four passes through the shared divider
// (start, two product steps, 64 quotient bits, take); tick word: result valid
// after the StSum state. One word in flight at a time; input ready again in
// the cycle after the result is taken.
// Reset: async active low; stored counters zero, fault cleared, registers at
// limit 95 and timeouts 10.
module cpu_load_percent_fault_monitor
  import clpfm_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            kind_i,
  input  logic [IdxW-1:0] cpu_index_i,
  input  cnt_t            user_ticks_i,
  input  cnt_t            nice_ticks_i,
  input  cnt_t            system_ticks_i,
  input  cnt_t            idle_ticks_i,
  input  cnt_t            iowait_ticks_i,
  input  cnt_t            irq_ticks_i,
  input  cnt_t            softirq_ticks_i,
  input  cnt_t            steal_ticks_i,
  input  cnt_t            guest_ticks_i,
  input  cnt_t            guest_nice_ticks_i,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_index_i,
  input  logic [15:0]     cfg_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [IdxW-1:0] cpu_index_out_o,
  output logic [PctW-1:0] nice_pct_o,
  output logic [PctW-1:0] user_pct_o,
  output logic [PctW-1:0] system_pct_o,
  output logic [PctW-1:0] virt_pct_o,
  output logic [PctW-1:0] total_pct_o,
  output logic [1:0]      fault_status_o,
  output logic [PctW-1:0] high_load_avg_o,
  output logic [1:0]      fault_event_o
);

  typedef enum logic [2:0] {StIdle, StSum, StDiff, StDiv, StWait, StFault, StOut} st_e;

  st_e state_q;
  logic [6:0]  limit_q;
  logic [15:0] atmo_q, ctmo_q, acnt_q, ccnt_q;
  logic [1:0]  phase_q, event_q;
  logic [PctW-1:0] avg_q;
  logic        kind_q;
  logic [IdxW-1:0] idx_q;
  cnt_t u_q, n_q, s_q, i_q, w_q, st_q, g_q, gn_q;
  cnt_t prev_u_q [Depth], prev_n_q [Depth], prev_st_q [Depth];
  cnt_t prev_v_q [Depth], prev_s_q [Depth], prev_t_q [Depth];
  cnt_t d_n_q, d_u_q, d_s_q, d_v_q, d_t_q;
  logic [1:0] dsel_q;
  logic [PctW-1:0] p_q [4];
  logic [PctW+1:0] psum;
  logic [PctW-1:0] ptot;
  div_req_t dreq;
  div_rsp_t drsp;
  logic [SlotW-1:0] slot;
  logic idx_ok;
  cnt_t user_w, nice_w, sys_w, virt_w, tot_w;
  logic [CountWidth:0] vsum;

  assign slot   = idx_q[SlotW-1:0];
  assign idx_ok = (idx_q <= IdxW'(NumCpus));

  always_comb begin
    user_w = u_q - g_q;
    nice_w = n_q - gn_q;
    sys_w  = s_q;
    virt_w = g_q + gn_q;
    // guest terms cancel out of the grand total
    tot_w  = u_q + n_q + s_q + i_q + w_q + st_q;
    vsum   = {1'b0, d_v_q} + {1'b0, st_q - prev_st_q[slot]};
    psum   = {2'b0, p_q[0]} + {2'b0, p_q[1]} + {2'b0, p_q[2]} + {2'b0, p_q[3]};
    ptot   = (psum > (PctW+2)'(FullPct)) ? FullPct : psum[PctW-1:0];
  end

  always_comb begin
    dreq.start = (state_q == StDiv);
    dreq.den   = d_t_q;
    case (dsel_q)
      2'd0:    dreq.num = d_n_q;
      2'd1:    dreq.num = d_u_q;
      2'd2:    dreq.num = d_s_q;
      default: dreq.num = d_v_q;
    endcase
  end

  clpfm_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // register writes take effect at the next edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 7'd95;
      atmo_q  <= 16'd10;
      ctmo_q  <= 16'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegLoadLimit:     limit_q <= cfg_data_i[6:0];
        RegAssertTimeout: atmo_q  <= cfg_data_i;
        RegClearTimeout:  ctmo_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      phase_q <= PhCleared;
      event_q <= EvNone;
      avg_q   <= '0;
      acnt_q  <= '0;
      ccnt_q  <= '0;
      dsel_q  <= '0;
      for (int k = 0; k < Depth; k++) begin
        prev_u_q[k] <= '0; prev_n_q[k] <= '0; prev_st_q[k] <= '0;
        prev_v_q[k] <= '0; prev_s_q[k] <= '0; prev_t_q[k] <= '0;
      end
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            kind_q <= kind_i;
            idx_q  <= cpu_index_i;
            u_q <= user_ticks_i; n_q <= nice_ticks_i; i_q <= idle_ticks_i;
            w_q <= iowait_ticks_i; st_q <= steal_ticks_i; g_q <= guest_ticks_i;
            gn_q <= guest_nice_ticks_i;
            s_q <= system_ticks_i + irq_ticks_i + softirq_ticks_i;
            event_q <= EvNone;
            for (int k = 0; k < 4; k++) p_q[k] <= '0;
            state_q <= StSum;
          end
        end
        StSum: begin
          if (kind_q) begin
            if (acnt_q != '0) begin
              acnt_q <= acnt_q - 1'b1;
              if (acnt_q == 16'd1) begin phase_q <= PhAsserted; event_q <= EvAsserted; end
            end
            if (ccnt_q != '0) begin
              ccnt_q <= ccnt_q - 1'b1;
              if (ccnt_q == 16'd1) begin phase_q <= PhCleared; event_q <= EvCleared; end
            end
            state_q <= StOut;
          end else if (!idx_ok) begin
            state_q <= StOut;
          end else begin
            d_u_q <= user_w - prev_u_q[slot];
            d_n_q <= nice_w - prev_n_q[slot];
            d_s_q <= sys_w - prev_s_q[slot];
            d_v_q <= virt_w - prev_v_q[slot];
            d_t_q <= tot_w - prev_t_q[slot];
            prev_u_q[slot] <= user_w; prev_n_q[slot] <= nice_w;
            prev_s_q[slot] <= sys_w;  prev_v_q[slot] <= virt_w;
            prev_t_q[slot] <= tot_w;
            state_q <= StDiff;
          end
        end
        StDiff: begin
          if (d_t_q == '0) d_t_q <= cnt_t'(1);
          d_v_q <= vsum[CountWidth] ? '1 : vsum[CountWidth-1:0];
          prev_st_q[slot] <= st_q;
          dsel_q  <= '0;
          state_q <= StDiv;
        end
        StDiv: state_q <= StWait;
        StWait: begin
          if (drsp.done) begin
            p_q[dsel_q] <= drsp.pct;
            dsel_q <= dsel_q + 1'b1;
            state_q <= (dsel_q == 2'd3) ? StFault : StDiv;
          end
        end
        StFault: begin
          if (idx_q == '0) begin
            if (ptot > {limit_q, 8'd0}) begin
              if (phase_q == PhClearing) begin
                ccnt_q <= '0; phase_q <= PhAsserted;
              end else if (phase_q == PhCleared) begin
                acnt_q <= (atmo_q == '0) ? 16'd1 : atmo_q;
                phase_q <= PhAsserting;
                avg_q <= ptot;
              end else if (phase_q == PhAsserting) begin
                avg_q <= PctW'(({1'b0, avg_q} + {1'b0, ptot}) >> 1);
              end
            end else begin
              if (phase_q == PhAsserting) begin
                acnt_q <= '0; phase_q <= PhCleared;
              end else if (phase_q == PhAsserted) begin
                ccnt_q <= (ctmo_q == '0) ? 16'd1 : ctmo_q;
                phase_q <= PhClearing;
              end
            end
          end
          state_q <= StOut;
        end
        StOut: if (out_ready_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_ready_o      = (state_q == StIdle);
  assign out_valid_o     = (state_q == StOut);
  assign cpu_index_out_o = kind_q ? '0 : idx_q;
  assign nice_pct_o      = p_q[0];
  assign user_pct_o      = p_q[1];
  assign system_pct_o    = p_q[2];
  assign virt_pct_o      = p_q[3];
  assign total_pct_o     = ptot;
  assign fault_status_o  = phase_q;
  assign high_load_avg_o = avg_q;
  assign fault_event_o   = event_q;

  a_one_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(acnt_q != '0 && ccnt_q != '0)) else $error("both countdowns running");
  a_snap_ev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !kind_q) |-> fault_event_o == EvNone) else $error("snapshot event");
  a_tot_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> total_pct_o <= FullPct) else $error("total above full scale");

endmodule
